// ===== sv/rpte_pkg.sv =====
// Package for the rectangle pixel transfer engine.
// Holds sizes, register and mode codes, the palette port structs and helper functions.
// No dependencies.
`default_nettype none

package rpte_pkg;

  // Largest rectangle side and number of palette entries.
  localparam int MAX_DIM         = 1024;
  localparam int PALETTE_ENTRIES = 256;

  // Derived widths.
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = CNT_W + 1;
  localparam int PAL_AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int ADDR_W  = 22;
  localparam int PIX_W   = 32;
  localparam int SUM_W   = ((CNT_W > 10) ? CNT_W : 10) + 1;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_STRIDE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_STRIDE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_X      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_Y      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_X      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_Y      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_W     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_H     = 4'd7;

  // Operating modes.
  localparam logic [1:0] MODE_FILL    = 2'd0;
  localparam logic [1:0] MODE_COPY    = 2'd1;
  localparam logic [1:0] MODE_CONVERT = 2'd2;
  localparam logic [1:0] MODE_PAL_WR  = 2'd3;

  // Palette write and read requests.
  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

  // Effective rectangle side: zero reads as one, large values clamp to MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [10:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      return DIM_W'(1);
    end else if (v32 > 32'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v32);
    end
  endfunction

  // Swap bytes 0 and 2 of a pixel.
  function automatic logic [PIX_W-1:0] swap_r_b(input logic [PIX_W-1:0] v);
    return {v[31:24], v[7:0], v[15:8], v[23:16]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/rpte_if.sv =====
// Channel interfaces of the rectangle pixel transfer engine: input, result and config.
// Depends on rpte_pkg for field widths.
`default_nettype none

// Input item channel.
interface rpte_in_if;
  import rpte_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [PIX_W-1:0] pixel_in;
  logic [7:0]       entry_index;

  modport source (output valid, mode, pixel_in, entry_index, input ready);
  modport sink (input valid, mode, pixel_in, entry_index, output ready);
endinterface

// Result item channel.
interface rpte_out_if;
  import rpte_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dst_addr;
  logic [PIX_W-1:0]  pixel_out;
  logic              last_of_rect;

  modport source (output valid, src_addr, dst_addr, pixel_out, last_of_rect, input ready);
  modport sink (input valid, src_addr, dst_addr, pixel_out, last_of_rect, output ready);
endinterface

// Configuration write channel.
interface rpte_cfg_if;
  import rpte_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/rpte_palette.sv =====
// Palette memory of the rectangle pixel transfer engine: one write and one read port,
// registered read data, and a valid bit per entry so unwritten entries read as zero.
// Depends on rpte_pkg.
`default_nettype none

module rpte_palette (
  input  wire                      clk,
  input  wire                      rst_n,
  input  rpte_pkg::pal_wr_t        wr,
  input  rpte_pkg::pal_rd_t        rd,
  output logic [rpte_pkg::PIX_W-1:0] rd_data
);
  import rpte_pkg::*;

  logic [PIX_W-1:0]           mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] valid_r;
  logic [PIX_W-1:0]           rd_data_r;
  logic                       rd_valid_r;

  // Memory array: write and registered read.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  // Per-entry valid bits, cleared by reset, and the valid bit of the read beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid_r <= valid_r[rd.addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ===== sv/rect_pixel_transfer_engine.sv =====
// Top level of the rectangle pixel transfer engine.
// Depends on rpte_pkg, the channel interfaces in rpte_if and the palette memory rpte_palette.
`default_nettype none

// The engine accepts one input beat per clock while the result side is not stalled; each
// accepted beat then passes its stages in order: one stage forms the row products and
// reads the palette memory through its registered read port, the next adds the column
// offsets into the output register. Palette write beats load an entry and give no result.
// Counters advance in raster order at each accepted fill, copy or convert beat and wrap
// after the last element of the rectangle. The palette reads as zero after reset through
// per-entry valid bits, so no clearing pass is needed. Configuration beats are always
// accepted and must only be sent while no result is pending.
module rect_pixel_transfer_engine (
  input wire        clk,
  input wire        rst_n,
  rpte_in_if.sink   in_ch,
  rpte_out_if.source out_ch,
  rpte_cfg_if.sink  cfg_ch
);
  import rpte_pkg::*;

  // Configuration registers.
  logic [10:0] src_stride_r, dst_stride_r, rect_w_r, rect_h_r;
  logic [9:0]  src_x_r, src_y_r, dst_x_r, dst_y_r;

  // Raster counters.
  logic [CNT_W-1:0] col_r, row_r, col_nxt, row_nxt;

  // First stage.
  logic              s1_valid_r;
  logic [1:0]        s1_mode_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [CNT_W-1:0]  s1_col_r;
  logic [ADDR_W-1:0] s1_src_prod_r, s1_dst_prod_r, s1_pk_prod_r;
  logic              s1_idx_ok_r;
  logic              s1_last_r;

  // Output register.
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_src_addr_r, out_dst_addr_r;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_last_r;

  logic              in_fire, elem_fire, s1_go;
  logic [DIM_W-1:0]  eff_w, eff_h, col_inc, row_inc;
  logic              col_end, last;
  logic [SUM_W-1:0]  src_row, dst_row;
  logic [ADDR_W-1:0] src_prod, dst_prod, pk_prod;
  logic              idx_ok;
  pal_wr_t           pal_wr;
  pal_rd_t           pal_rd;
  logic [PIX_W-1:0]  pal_data;
  logic [ADDR_W-1:0] src_addr_nxt, dst_addr_nxt;
  logic [PIX_W-1:0]  pixel_nxt;

  // Handshakes.
  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign elem_fire   = in_fire && (in_ch.mode != MODE_PAL_WR);
  assign cfg_ch.ready = 1'b1;

  // Configuration writes, masked to each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_stride_r <= 11'd400;
      dst_stride_r <= 11'd400;
      src_x_r      <= '0;
      src_y_r      <= '0;
      dst_x_r      <= '0;
      dst_y_r      <= '0;
      rect_w_r     <= 11'd1;
      rect_h_r     <= 11'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SRC_STRIDE: src_stride_r <= cfg_ch.data[10:0];
        REG_DST_STRIDE: dst_stride_r <= cfg_ch.data[10:0];
        REG_SRC_X:      src_x_r      <= cfg_ch.data[9:0];
        REG_SRC_Y:      src_y_r      <= cfg_ch.data[9:0];
        REG_DST_X:      dst_x_r      <= cfg_ch.data[9:0];
        REG_DST_Y:      dst_y_r      <= cfg_ch.data[9:0];
        REG_RECT_W:     rect_w_r     <= cfg_ch.data[10:0];
        REG_RECT_H:     rect_h_r     <= cfg_ch.data[10:0];
        default: ;
      endcase
    end
  end

  // End-of-row and end-of-rectangle detection; a counter past the end counts as at it.
  always_comb begin
    eff_w   = eff_dim(rect_w_r);
    eff_h   = eff_dim(rect_h_r);
    col_inc = DIM_W'(col_r) + DIM_W'(1);
    row_inc = DIM_W'(row_r) + DIM_W'(1);
    col_end = (col_inc >= eff_w);
    last    = col_end && (row_inc >= eff_h);
    col_nxt = col_end ? '0 : col_inc[CNT_W-1:0];
    row_nxt = col_end ? (last ? '0 : row_inc[CNT_W-1:0]) : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (elem_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Row base products, modulo the address width.
  always_comb begin
    src_row  = SUM_W'(src_y_r) + SUM_W'(row_r);
    dst_row  = SUM_W'(dst_y_r) + SUM_W'(row_r);
    src_prod = ADDR_W'(src_row) * ADDR_W'(src_stride_r);
    dst_prod = ADDR_W'(dst_row) * ADDR_W'(dst_stride_r);
    pk_prod  = ADDR_W'(row_r) * ADDR_W'(eff_w);
    idx_ok   = (9'(in_ch.pixel_in[7:0]) < 9'(PALETTE_ENTRIES));
  end

  // Palette requests.
  always_comb begin
    pal_wr.en   = in_fire && (in_ch.mode == MODE_PAL_WR) &&
                  (9'(in_ch.entry_index) < 9'(PALETTE_ENTRIES));
    pal_wr.addr = in_ch.entry_index[PAL_AW-1:0];
    pal_wr.data = in_ch.pixel_in;
    pal_rd.en   = in_fire && (in_ch.mode == MODE_CONVERT);
    pal_rd.addr = in_ch.pixel_in[PAL_AW-1:0];
  end

  rpte_palette u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (pal_wr),
    .rd      (pal_rd),
    .rd_data (pal_data)
  );

  // First stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= elem_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (elem_fire) begin
      s1_mode_r     <= in_ch.mode;
      s1_pix_r      <= in_ch.pixel_in;
      s1_col_r      <= col_r;
      s1_src_prod_r <= src_prod;
      s1_dst_prod_r <= dst_prod;
      s1_pk_prod_r  <= pk_prod;
      s1_idx_ok_r   <= idx_ok;
      s1_last_r     <= last;
    end
  end

  // Final addresses and pixel value.
  always_comb begin
    src_addr_nxt = '0;
    if (s1_mode_r != MODE_FILL) begin
      src_addr_nxt = s1_src_prod_r + ADDR_W'(src_x_r) + ADDR_W'(s1_col_r);
    end
    if (s1_mode_r == MODE_CONVERT) begin
      dst_addr_nxt = s1_pk_prod_r + ADDR_W'(s1_col_r);
      pixel_nxt    = s1_idx_ok_r ? swap_r_b(pal_data) : '0;
    end else begin
      dst_addr_nxt = s1_dst_prod_r + ADDR_W'(dst_x_r) + ADDR_W'(s1_col_r);
      pixel_nxt    = s1_pix_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_src_addr_r <= src_addr_nxt;
      out_dst_addr_r <= dst_addr_nxt;
      out_pixel_r    <= pixel_nxt;
      out_last_r     <= s1_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.src_addr     = out_src_addr_r;
  assign out_ch.dst_addr     = out_dst_addr_r;
  assign out_ch.pixel_out    = out_pixel_r;
  assign out_ch.last_of_rect = out_last_r;

endmodule

`default_nettype wire

// ===== tb/sv/rpte_xfer_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the rectangle pixel transfer engine.
// It watches the input, result and configuration channels, keeps its own model of the
// engine and compares every result beat. Depends on rpte_pkg and the interfaces in rpte_if.

module rpte_xfer_checker
  import rpte_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  rpte_in_if   in_ch,
  rpte_out_if  out_ch,
  rpte_cfg_if  cfg_ch,
  output int   mismatches,
  output int   pending,
  output int   checked
);

  // One predicted result beat.
  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PIX_W-1:0]  pixel_out;
    logic              last_of_rect;
  } pixel_xfer_t;

  pixel_xfer_t xfer_expected_q[$];

  // Local copy of the registers, the raster counters and the palette.
  logic [10:0]      src_stride_r, dst_stride_r, rect_w_r, rect_h_r;
  logic [9:0]       src_x_r, src_y_r, dst_x_r, dst_y_r;
  int unsigned      col_pos, row_pos;
  logic [PIX_W-1:0] palette_copy [PALETTE_ENTRIES];

  // A zero side acts as one and anything above the largest side is clamped.
  function automatic int unsigned clamp_side(input logic [10:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Register writes keep only the bits of the register's width.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SRC_STRIDE: src_stride_r = data[10:0];
      REG_DST_STRIDE: dst_stride_r = data[10:0];
      REG_SRC_X:      src_x_r      = data[9:0];
      REG_SRC_Y:      src_y_r      = data[9:0];
      REG_DST_X:      dst_x_r      = data[9:0];
      REG_DST_Y:      dst_y_r      = data[9:0];
      REG_RECT_W:     rect_w_r     = data[10:0];
      REG_RECT_H:     rect_h_r     = data[10:0];
      default: ;
    endcase
  endfunction

  // Work out the result of the current rectangle element and step the raster counters.
  function automatic pixel_xfer_t next_element(input logic [1:0] mode,
                                               input logic [PIX_W-1:0] pix);
    int unsigned      w, h, sa, da;
    logic [PIX_W-1:0] entry;
    logic             row_done;
    pixel_xfer_t      res;
    w  = clamp_side(rect_w_r);
    h  = clamp_side(rect_h_r);
    sa = 0;
    if (mode != MODE_FILL) begin
      sa = (src_y_r + row_pos) * src_stride_r + src_x_r + col_pos;
    end
    if (mode == MODE_CONVERT) begin
      entry         = palette_copy[pix[7:0]];
      da            = row_pos * w + col_pos;
      res.pixel_out = {entry[31:24], entry[7:0], entry[15:8], entry[23:16]};
    end else begin
      da            = (dst_y_r + row_pos) * dst_stride_r + dst_x_r + col_pos;
      res.pixel_out = pix;
    end
    res.src_addr = sa[ADDR_W-1:0];
    res.dst_addr = da[ADDR_W-1:0];
    // A counter at or past the end, e.g. after a shrink, counts as the end.
    row_done         = (col_pos + 1 >= w);
    res.last_of_rect = row_done && (row_pos + 1 >= h);
    if (!row_done) begin
      col_pos = col_pos + 1;
    end else begin
      col_pos = 0;
      row_pos = res.last_of_rect ? 0 : row_pos + 1;
    end
    return res;
  endfunction

  // Sample all channels at the rising edge.
  always @(posedge clk) begin
    pixel_xfer_t want;
    if (!rst_n) begin
      src_stride_r = 11'd400;
      dst_stride_r = 11'd400;
      src_x_r      = '0;
      src_y_r      = '0;
      dst_x_r      = '0;
      dst_y_r      = '0;
      rect_w_r     = 11'd1;
      rect_h_r     = 11'd1;
      col_pos      = 0;
      row_pos      = 0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) palette_copy[i] = '0;
      xfer_expected_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_reg(cfg_ch.index, cfg_ch.data);
      end
      // Palette loads give no result; every other mode gives one.
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_PAL_WR) begin
          palette_copy[in_ch.entry_index] = in_ch.pixel_in;
        end else begin
          xfer_expected_q.push_back(next_element(in_ch.mode, in_ch.pixel_in));
        end
      end
      // Compare each result beat with the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        if (xfer_expected_q.size() == 0) begin
          $error("unexpected result beat: src_addr 0x%0h dst_addr 0x%0h pixel_out 0x%0h",
                 out_ch.src_addr, out_ch.dst_addr, out_ch.pixel_out);
          mismatches++;
        end else begin
          want = xfer_expected_q.pop_front();
          checked++;
          if (out_ch.src_addr !== want.src_addr) begin
            $error("src_addr: expected 0x%0h, actual 0x%0h", want.src_addr, out_ch.src_addr);
            mismatches++;
          end
          if (out_ch.dst_addr !== want.dst_addr) begin
            $error("dst_addr: expected 0x%0h, actual 0x%0h", want.dst_addr, out_ch.dst_addr);
            mismatches++;
          end
          if (out_ch.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected 0x%0h, actual 0x%0h", want.pixel_out,
                   out_ch.pixel_out);
            mismatches++;
          end
          if (out_ch.last_of_rect !== want.last_of_rect) begin
            $error("last_of_rect: expected %0b, actual %0b", want.last_of_rect,
                   out_ch.last_of_rect);
            mismatches++;
          end
        end
      end
    end
    pending = xfer_expected_q.size();
  end

endmodule

// ===== tb/sv/tb_rect_pixel_transfer_engine.sv =====
`timescale 1ns / 1ps
// Top of the rectangle pixel transfer engine testbench: clock, reset, stimulus and verdict.
// Depends on rpte_pkg, the interfaces in rpte_if, the engine and rpte_xfer_checker.

module tb_rect_pixel_transfer_engine;
  import rpte_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_CYCLES     = 150;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASES          = 12;
  localparam int BEATS_PER_PHASE = 70;
  localparam int HOLD_PHASE      = 4;
  localparam int REG_COUNT       = 8;

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   hold_start;
  int   mismatches, pending, checked;
  int   beats_sent;
  int   settings_done;

  rpte_in_if  in_ch();
  rpte_out_if out_ch();
  rpte_cfg_if cfg_ch();

  rect_pixel_transfer_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rpte_xfer_checker u_xfer_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Result side: random stall bursts, one long hold-off on request, none when quiet.
  initial begin : receiver
    bit hold_served;
    hold_served  = 1'b0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_served) begin
        hold_served  = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ch.ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Stop the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int still_cycles;
    still_cycles = 0;
    while (still_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        still_cycles = 0;
      end else begin
        still_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one input beat, maybe after a random gap; valid stays high on return.
  task automatic send_beat(input logic [1:0] mode, input logic [PIX_W-1:0] pix,
                           input logic [7:0] ent);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) begin
        in_ch.mode        = 2'($urandom);
        in_ch.pixel_in    = $urandom;
        in_ch.entry_index = 8'($urandom);
        @(negedge clk);
      end
    end
    in_ch.valid       = 1'b1;
    in_ch.mode        = mode;
    in_ch.pixel_in    = pix;
    in_ch.entry_index = ent;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  // Write one register; valid is left high for the next write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Load a full register setting; the bits above each register's width are random.
  task automatic write_setting(input logic [10:0] ss, ds, input logic [9:0] sx, sy, dx, dy,
                               input logic [10:0] w, h);
    write_reg(REG_SRC_STRIDE, {5'($urandom), ss});
    write_reg(REG_DST_STRIDE, {5'($urandom), ds});
    write_reg(REG_SRC_X, {6'($urandom), sx});
    write_reg(REG_SRC_Y, {6'($urandom), sy});
    write_reg(REG_DST_X, {6'($urandom), dx});
    write_reg(REG_DST_Y, {6'($urandom), dy});
    write_reg(REG_RECT_W, {5'($urandom), w});
    write_reg(REG_RECT_H, {5'($urandom), h});
    // Writes beyond the register list must change nothing.
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)), 16'($urandom));
    end
    cfg_ch.valid = 1'b0;
    settings_done++;
  endtask

  // Drain all predicted results, then let palette loads still in flight settle.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Main stimulus.
  initial begin : stimulus
    logic [10:0] ss, ds, w, h;
    logic [9:0]  sx, sy, dx, dy;
    int          pick;
    rst_n             = 1'b0;
    quiet             = 1'b0;
    hold_start        = 1'b0;
    beats_sent        = 0;
    settings_done     = 0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_FILL;
    in_ch.pixel_in    = '0;
    in_ch.entry_index = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_SRC_STRIDE;
    cfg_ch.data       = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset setting: every element is a whole rectangle.
    send_beat(MODE_PAL_WR, 32'hFFFF_FFFF, 8'd0);
    send_beat(MODE_PAL_WR, 32'h1234_5678, 8'd255);
    send_beat(MODE_PAL_WR, 32'h00A1_B2C3, 8'd128);
    send_beat(MODE_CONVERT, 32'h0000_0000, 8'd0);
    send_beat(MODE_CONVERT, 32'hFFFF_FFFF, 8'd255);
    // An entry never loaded reads as zero; upper index bits are ignored.
    send_beat(MODE_CONVERT, 32'h0000_0007, 8'd0);
    send_beat(MODE_CONVERT, 32'h5555_AA80, 8'd0);
    // Fill gives a zero source address.
    send_beat(MODE_FILL, 32'h0000_0000, 8'd0);
    send_beat(MODE_FILL, 32'hFFFF_FFFF, 8'd255);
    send_beat(MODE_COPY, 32'h0000_0000, 8'd0);
    send_beat(MODE_COPY, 32'hFFFF_FFFF, 8'd255);
    send_beat(MODE_PAL_WR, 32'h0000_0000, 8'd0);
    send_beat(MODE_CONVERT, 32'hABCD_EF00, 8'd0);
    wait_idle();

    // A 2x2 rectangle with mode changes and a palette load in the middle.
    write_setting(11'd37, 11'd64, 10'd5, 10'd9, 10'd1023, 10'd1023, 11'd2, 11'd2);
    send_beat(MODE_FILL, 32'hCAFE_0001, 8'd0);
    send_beat(MODE_COPY, 32'h8000_0000, 8'd0);
    send_beat(MODE_PAL_WR, 32'h0102_0304, 8'd77);
    send_beat(MODE_CONVERT, 32'h0000_004D, 8'd0);
    send_beat(MODE_COPY, 32'h0000_0001, 8'd0);
    send_beat(MODE_FILL, 32'h7FFF_FFFF, 8'd0);
    wait_idle();

    // Random phases: extreme settings first, then mostly small rectangles.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          ss = 11'd1; ds = 11'd1; sx = '0; sy = '0; dx = '0; dy = '0;
          w = 11'd1; h = 11'd1;
        end
        1: begin
          ss = 11'd1024; ds = 11'd1024; sx = 10'd1023; sy = 10'd1023;
          dx = 10'd1023; dy = 10'd1023; w = 11'd1024; h = 11'd1024;
        end
        // Out-of-range strides and sides.
        2: begin
          ss = 11'd0; ds = 11'd2047; sx = 10'($urandom); sy = 10'($urandom);
          dx = 10'($urandom); dy = 10'($urandom); w = 11'd0; h = 11'd2047;
        end
        3: begin
          ss = 11'd2047; ds = 11'd0; sx = 10'd1023; sy = 10'd1023;
          dx = 10'd1023; dy = 10'd1023; w = 11'd2047; h = 11'd0;
        end
        default: begin
          ss = ($urandom_range(0, 5) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
          ds = ($urandom_range(0, 5) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
          sx = 10'($urandom); sy = 10'($urandom);
          dx = 10'($urandom); dy = 10'($urandom);
          w  = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(9, 40))
                                           : 11'($urandom_range(1, 8));
          h  = 11'($urandom_range(1, 6));
        end
      endcase
      write_setting(ss, ds, sx, sy, dx, dy, w, h);
      quiet = (phase >= PHASES - 2);
      if (phase == HOLD_PHASE) hold_start = 1'b1;
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) send_beat(MODE_FILL, $urandom, 8'($urandom));
        else if (pick < 5) send_beat(MODE_COPY, $urandom, 8'($urandom));
        else if (pick < 8) send_beat(MODE_CONVERT, $urandom, 8'($urandom));
        else send_beat(MODE_PAL_WR, $urandom, 8'($urandom));
      end
      wait_idle();
    end

    $display("Run summary: %0d input beats over %0d register settings, %0d results checked.",
             beats_sent, settings_done, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rpte_pkg.sv
sv/rpte_if.sv
sv/rpte_palette.sv
sv/rect_pixel_transfer_engine.sv
tb/sv/rpte_xfer_checker.sv
tb/sv/tb_rect_pixel_transfer_engine.sv
